/* rtl/salcp_pkg.sv */
// ----------------------------------------------------------------------------
// salcp_pkg
// shared sizes, datapath operation codes and status bundle for the suffix
// array / lcp unit
// ----------------------------------------------------------------------------
package salcp_pkg;

    localparam int MAX_LEN  = 1024;
    localparam int ALPHABET = 256;
    localparam int BUCKETS  = (ALPHABET > MAX_LEN) ? ALPHABET : MAX_LEN;
    localparam int AW       = $clog2(MAX_LEN);
    localparam int LW       = AW + 1;
    localparam int SW       = 8;

    typedef enum logic [5:0] {
        OP_NOP, OP_LOAD, OP_QUERY, OP_OUT, OP_CLR,
        OP_IC1, OP_IC2, OP_IC3,
        OP_DC1, OP_DC2, OP_DC3, OP_DC4,
        OP_PR1, OP_PR2,
        OP_IP1, OP_IP2, OP_IP3,
        OP_IK1, OP_IK2, OP_IK3,
        OP_SH1, OP_SH2,
        OP_DP1, OP_DP2, OP_DP3, OP_DP4,
        OP_DK1, OP_DK2, OP_DK3, OP_DK4,
        OP_CP1, OP_CP2, OP_STEP,
        OP_RK1, OP_RK2,
        OP_LC1, OP_LC2, OP_LC3, OP_LC4, OP_LC5, OP_LC6, OP_LNX
    } t_op;

    typedef struct packed {
        logic end_n;
        logic end_bk;
        logic end_lim;
        logic i_zero;
        logic init;
        logic step_go;
        logic r_last;
        logic scan_ok;
        logic sym_eq;
    } t_stat;

endpackage

/* rtl/suffix_array_with_lcp_unit.sv */
// ----------------------------------------------------------------------------
// suffix_array_with_lcp_unit
// loads a byte text, builds its suffix array by prefix doubling and the lcp
// table by kasai's scan, then answers rank queries
// ----------------------------------------------------------------------------
// channel  dir  tdata                                        tuser  tlast
// s        in   symbol[7:0] rank[17:8]                       func   last
// m        out  start[9:0] lcp[19:10] next[20] inr[21] ovf[22] -    -
//
// load beats go in at one per cycle while the unit is idle; a query result beat
// is set by the registered memory read and then the output register
// after a last beat the sort runs its doubling rounds, then kasai's lcp scan
// no beat is taken while sorting or while a result beat waits
// reset is synchronous, active low; it drops any held text
// ----------------------------------------------------------------------------
module suffix_array_with_lcp_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // symbol[7:0], rank[17:8]
    input  logic        i_s_tuser,   // func
    input  logic        i_s_tlast,   // last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // start, lcp, has_next, in_range, overflowed
);
    salcp_pkg::t_op   op;
    salcp_pkg::t_stat stat;
    logic [salcp_pkg::AW-1:0] start, cp;
    logic hn, ir, ov, accept;

    assign accept = i_s_tvalid && o_s_tready;

    salcp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_func      (i_s_tuser),
        .i_last      (i_s_tlast),
        .i_out_taken (o_m_tvalid && i_m_tready),
        .i_stat      (stat),
        .o_op        (op),
        .o_ready     (o_s_tready),
        .o_out_valid (o_m_tvalid)
    );

    salcp_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op),
        .i_sym   (i_s_tdata[7:0]),
        .i_rank  (i_s_tdata[17:8]),
        .o_stat  (stat),
        .o_start (start),
        .o_cp    (cp),
        .o_hn    (hn),
        .o_ir    (ir),
        .o_ov    (ov)
    );

    assign o_m_tdata = {1'b0, ov, ir, hn, cp, start};

`ifndef SYNTHESIS
    a_no_take_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input taken while a result beat waits");
    a_query_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_tuser) |=> ##1 o_m_tvalid)
        else $error("query gave no result beat");
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_s_tuser && !o_m_tvalid) |=> !o_m_tvalid)
        else $error("load produced a result beat");
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[21]) |-> (o_m_tdata[20:0] == 21'd0))
        else $error("out of range result not zero");
`endif

endmodule

/* rtl/salcp_dp.sv */
// ----------------------------------------------------------------------------
// salcp_dp
// datapath: text, order, class, count, rank and lcp memories with the index
// registers, executing one operation per cycle from the controller
// ----------------------------------------------------------------------------
module salcp_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  salcp_pkg::t_op             i_op,
    input  logic [salcp_pkg::SW-1:0]   i_sym,
    input  logic [salcp_pkg::AW-1:0]   i_rank,
    output salcp_pkg::t_stat           o_stat,
    output logic [salcp_pkg::AW-1:0]   o_start,
    output logic [salcp_pkg::AW-1:0]   o_cp,
    output logic                       o_hn,
    output logic                       o_ir,
    output logic                       o_ov
);
    localparam int AW = salcp_pkg::AW;
    localparam int LW = salcp_pkg::LW;
    localparam int SW = salcp_pkg::SW;
    localparam int N  = salcp_pkg::MAX_LEN;

    logic [SW-1:0] m_txt  [N];
    logic [AW-1:0] m_sa   [N];
    logic [AW-1:0] m_tmp  [N];
    logic [AW-1:0] m_cls  [N];
    logic [AW-1:0] m_ncls [N];
    logic [LW-1:0] m_cnt  [salcp_pkg::BUCKETS];
    logic [AW-1:0] m_rk   [N];
    logic [AW-1:0] m_lcp  [N];

    logic          txt_we, txt_re, sa_we, sa_re, tmp_we, tmp_re, cls_we, cls_re;
    logic          ncls_we, ncls_re, cnt_we, cnt_re, rk_we, lcp_we, lcp_re, rk_re;
    logic [AW-1:0] txt_wa, txt_ra, sa_wa, sa_ra, tmp_wa, tmp_ra, cls_wa, cls_ra;
    logic [AW-1:0] ncls_wa, ncls_ra, cnt_wa, cnt_ra, rk_wa, rk_ra, lcp_wa, lcp_ra;
    logic [SW-1:0] txt_wd;
    logic [AW-1:0] sa_wd, tmp_wd, cls_wd, ncls_wd, rk_wd, lcp_wd;
    logic [LW-1:0] cnt_wd;

    logic [SW-1:0] r_txt_q;
    logic [AW-1:0] r_sa_q, r_tmp_q, r_cls_q, r_ncls_q, r_rk_q, r_lcp_q;
    logic [LW-1:0] r_cnt_q;

    logic [LW-1:0] r_len, n_len, r_i, n_i, r_h, n_h, r_step, n_step;
    logic [LW-1:0] r_ct, n_ct, r_acc, n_acc;
    logic          r_ovf, n_ovf, r_ready, n_ready, r_init, n_init;
    logic          r_qin, n_qin, r_qnext, n_qnext;
    logic [AW-1:0] r_a, n_a, r_ca, n_ca, r_pca, n_pca, r_pcm, n_pcm;
    logic [AW-1:0] r_r, n_r, r_nx, n_nx;
    logic [SW-1:0] r_psym, n_psym, r_ta, n_ta;
    logic [AW-1:0] r_o_start, n_o_start, r_o_cp, n_o_cp;
    logic          r_o_hn, n_o_hn, r_o_ir, n_o_ir, r_o_ov, n_o_ov;

    logic [LW-1:0] len_m1, lim, base, ctn, dec, sum;
    logic [LW:0]   sh, ma_s, ih, nh;
    logic [AW-1:0] ma;
    logic          end_n;

    assign len_m1 = r_len - LW'(1);
    assign end_n  = (r_i == len_m1);
    assign lim    = r_init ? LW'(salcp_pkg::ALPHABET) : r_ct;
    // rotation start step positions back, wrapped into the text
    assign sh     = ({2'b0, r_sa_q} >= {1'b0, r_step})
                    ? {2'b0, r_sa_q} - {1'b0, r_step}
                    : {2'b0, r_sa_q} + {1'b0, r_len} - {1'b0, r_step};
    assign ma_s   = {2'b0, r_a} + {1'b0, r_step};
    assign ma     = (ma_s >= {1'b0, r_len}) ? AW'(ma_s - {1'b0, r_len}) : AW'(ma_s);
    assign ih     = {1'b0, r_i} + {1'b0, r_h};
    assign nh     = {2'b0, r_nx} + {1'b0, r_h};

    assign o_stat.end_n   = end_n;
    assign o_stat.end_bk  = (r_i == LW'(salcp_pkg::BUCKETS - 1));
    assign o_stat.end_lim = (r_i == lim - LW'(1));
    assign o_stat.i_zero  = (r_i == '0);
    assign o_stat.init    = r_init;
    assign o_stat.step_go = (r_step < r_len);
    assign o_stat.r_last  = ({1'b0, r_rk_q} == len_m1);
    assign o_stat.scan_ok = (ih < {1'b0, r_len}) && (nh < {1'b0, r_len});
    assign o_stat.sym_eq  = (r_txt_q == r_ta);

    assign o_start = r_o_start;
    assign o_cp    = r_o_cp;
    assign o_hn    = r_o_hn;
    assign o_ir    = r_o_ir;
    assign o_ov    = r_o_ov;

    always_comb begin
        txt_we = 1'b0; txt_re = 1'b0; txt_wa = '0; txt_ra = '0; txt_wd = '0;
        sa_we = 1'b0; sa_re = 1'b0; sa_wa = '0; sa_ra = '0; sa_wd = '0;
        tmp_we = 1'b0; tmp_re = 1'b0; tmp_wa = '0; tmp_ra = '0; tmp_wd = '0;
        cls_we = 1'b0; cls_re = 1'b0; cls_wa = '0; cls_ra = '0; cls_wd = '0;
        ncls_we = 1'b0; ncls_re = 1'b0; ncls_wa = '0; ncls_ra = '0; ncls_wd = '0;
        cnt_we = 1'b0; cnt_re = 1'b0; cnt_wa = '0; cnt_ra = '0; cnt_wd = '0;
        rk_we = 1'b0; rk_re = 1'b0; rk_wa = '0; rk_ra = '0; rk_wd = '0;
        lcp_we = 1'b0; lcp_re = 1'b0; lcp_wa = '0; lcp_ra = '0; lcp_wd = '0;
        n_len = r_len; n_i = r_i; n_h = r_h; n_step = r_step; n_ct = r_ct;
        n_acc = r_acc; n_ovf = r_ovf; n_ready = r_ready; n_init = r_init;
        n_qin = r_qin; n_qnext = r_qnext; n_a = r_a; n_ca = r_ca;
        n_pca = r_pca; n_pcm = r_pcm; n_r = r_r; n_nx = r_nx;
        n_psym = r_psym; n_ta = r_ta;
        n_o_start = r_o_start; n_o_cp = r_o_cp; n_o_hn = r_o_hn;
        n_o_ir = r_o_ir; n_o_ov = r_o_ov;
        base = r_ready ? '0 : r_len;
        ctn  = '0;
        dec  = r_cnt_q - LW'(1);
        sum  = r_acc + r_cnt_q;
        unique case (i_op)
            salcp_pkg::OP_NOP, salcp_pkg::OP_STEP: ;
            salcp_pkg::OP_PR1: begin
                cnt_re = 1'b1; cnt_ra = r_i[AW-1:0];
            end
            salcp_pkg::OP_LOAD: begin
                // first symbol after a finished sort starts a new text
                n_ready = 1'b0;
                n_ovf   = r_ready ? 1'b0 : r_ovf;
                if (base < LW'(N)) begin
                    txt_we = 1'b1; txt_wa = base[AW-1:0]; txt_wd = i_sym;
                    n_len  = base + LW'(1);
                end else begin
                    n_ovf = 1'b1;
                    n_len = base;
                end
                n_i = '0; n_init = 1'b1; n_step = LW'(1);
            end
            salcp_pkg::OP_QUERY: begin
                sa_re   = 1'b1; sa_ra = i_rank;
                lcp_re  = 1'b1; lcp_ra = i_rank;
                n_qin   = r_ready && ({1'b0, i_rank} < r_len);
                n_qnext = r_ready && (({1'b0, i_rank} + LW'(1)) < r_len);
            end
            salcp_pkg::OP_OUT: begin
                n_o_start = r_qin ? r_sa_q : '0;
                n_o_cp    = r_qnext ? r_lcp_q : '0;
                n_o_hn    = r_qnext;
                n_o_ir    = r_qin;
                n_o_ov    = r_ovf;
            end
            salcp_pkg::OP_CLR: begin
                cnt_we = 1'b1; cnt_wa = r_i[AW-1:0]; cnt_wd = '0;
                n_i = o_stat.end_bk ? '0 : r_i + LW'(1);
            end
            salcp_pkg::OP_IC1: begin txt_re = 1'b1; txt_ra = r_i[AW-1:0]; end
            salcp_pkg::OP_IC2: begin cnt_re = 1'b1; cnt_ra = AW'(r_txt_q); end
            salcp_pkg::OP_IC3: begin
                cnt_we = 1'b1; cnt_wa = AW'(r_txt_q); cnt_wd = r_cnt_q + LW'(1);
                n_i = end_n ? '0 : r_i + LW'(1);
                n_acc = '0;
            end
            salcp_pkg::OP_DC1: begin tmp_re = 1'b1; tmp_ra = r_i[AW-1:0]; end
            salcp_pkg::OP_DC2: begin cls_re = 1'b1; cls_ra = r_tmp_q; end
            salcp_pkg::OP_DC3: begin cnt_re = 1'b1; cnt_ra = r_cls_q; end
            salcp_pkg::OP_DC4: begin
                cnt_we = 1'b1; cnt_wa = r_cls_q; cnt_wd = r_cnt_q + LW'(1);
                n_i = end_n ? '0 : r_i + LW'(1);
                n_acc = '0;
            end
            salcp_pkg::OP_PR2: begin
                cnt_we = 1'b1; cnt_wa = r_i[AW-1:0]; cnt_wd = sum;
                n_acc = sum;
                if (o_stat.end_lim) n_i = r_init ? '0 : len_m1;
                else n_i = r_i + LW'(1);
            end
            salcp_pkg::OP_IP1: begin txt_re = 1'b1; txt_ra = r_i[AW-1:0]; end
            salcp_pkg::OP_IP2: begin cnt_re = 1'b1; cnt_ra = AW'(r_txt_q); end
            salcp_pkg::OP_IP3: begin
                cnt_we = 1'b1; cnt_wa = AW'(r_txt_q); cnt_wd = dec;
                sa_we = 1'b1; sa_wa = dec[AW-1:0]; sa_wd = r_i[AW-1:0];
                n_i = end_n ? '0 : r_i + LW'(1);
            end
            salcp_pkg::OP_IK1: begin sa_re = 1'b1; sa_ra = r_i[AW-1:0]; end
            salcp_pkg::OP_IK2: begin
                txt_re = 1'b1; txt_ra = r_sa_q; n_a = r_sa_q;
            end
            salcp_pkg::OP_IK3: begin
                ctn = (r_i == '0) ? LW'(1) : r_ct + LW'(r_txt_q != r_psym);
                cls_we = 1'b1; cls_wa = r_a; cls_wd = AW'(ctn - LW'(1));
                n_ct = ctn; n_psym = r_txt_q;
                if (end_n) begin
                    n_i = '0; n_init = 1'b0; n_step = LW'(1);
                end else begin
                    n_i = r_i + LW'(1);
                end
            end
            salcp_pkg::OP_SH1: begin sa_re = 1'b1; sa_ra = r_i[AW-1:0]; end
            salcp_pkg::OP_SH2: begin
                tmp_we = 1'b1; tmp_wa = r_i[AW-1:0]; tmp_wd = AW'(sh);
                n_i = end_n ? '0 : r_i + LW'(1);
            end
            salcp_pkg::OP_DP1: begin tmp_re = 1'b1; tmp_ra = r_i[AW-1:0]; end
            salcp_pkg::OP_DP2: begin cls_re = 1'b1; cls_ra = r_tmp_q; end
            salcp_pkg::OP_DP3: begin cnt_re = 1'b1; cnt_ra = r_cls_q; end
            salcp_pkg::OP_DP4: begin
                cnt_we = 1'b1; cnt_wa = r_cls_q; cnt_wd = dec;
                sa_we = 1'b1; sa_wa = dec[AW-1:0]; sa_wd = r_tmp_q;
                n_i = o_stat.i_zero ? '0 : r_i - LW'(1);
            end
            salcp_pkg::OP_DK1: begin sa_re = 1'b1; sa_ra = r_i[AW-1:0]; end
            salcp_pkg::OP_DK2: begin
                cls_re = 1'b1; cls_ra = r_sa_q; n_a = r_sa_q;
            end
            salcp_pkg::OP_DK3: begin
                n_ca = r_cls_q; cls_re = 1'b1; cls_ra = ma;
            end
            salcp_pkg::OP_DK4: begin
                ctn = (r_i == '0) ? LW'(1)
                      : r_ct + LW'((r_ca != r_pca) || (r_cls_q != r_pcm));
                ncls_we = 1'b1; ncls_wa = r_a; ncls_wd = AW'(ctn - LW'(1));
                n_ct = ctn; n_pca = r_ca; n_pcm = r_cls_q;
                n_i = end_n ? '0 : r_i + LW'(1);
            end
            salcp_pkg::OP_CP1: begin ncls_re = 1'b1; ncls_ra = r_i[AW-1:0]; end
            salcp_pkg::OP_CP2: begin
                cls_we = 1'b1; cls_wa = r_i[AW-1:0]; cls_wd = r_ncls_q;
                if (end_n) begin
                    n_i = '0; n_step = r_step << 1;
                end else begin
                    n_i = r_i + LW'(1);
                end
            end
            salcp_pkg::OP_RK1: begin sa_re = 1'b1; sa_ra = r_i[AW-1:0]; end
            salcp_pkg::OP_RK2: begin
                rk_we = 1'b1; rk_wa = r_sa_q; rk_wd = r_i[AW-1:0];
                n_i = end_n ? '0 : r_i + LW'(1);
                n_h = '0;
            end
            salcp_pkg::OP_LC1: begin rk_re = 1'b1; rk_ra = r_i[AW-1:0]; end
            salcp_pkg::OP_LC2: begin
                n_r = r_rk_q;
                if (o_stat.r_last) begin
                    lcp_we = 1'b1; lcp_wa = len_m1[AW-1:0]; lcp_wd = '0;
                    n_h = '0;
                end else begin
                    n_h = (r_h != '0) ? r_h - LW'(1) : r_h;
                    sa_re = 1'b1; sa_ra = r_rk_q + AW'(1);
                end
            end
            salcp_pkg::OP_LC3: n_nx = r_sa_q;
            salcp_pkg::OP_LC4: begin
                if (o_stat.scan_ok) begin
                    txt_re = 1'b1; txt_ra = ih[AW-1:0];
                end else begin
                    lcp_we = 1'b1; lcp_wa = r_r; lcp_wd = r_h[AW-1:0];
                end
            end
            salcp_pkg::OP_LC5: begin
                n_ta = r_txt_q; txt_re = 1'b1; txt_ra = nh[AW-1:0];
            end
            salcp_pkg::OP_LC6: begin
                if (o_stat.sym_eq) begin
                    n_h = r_h + LW'(1);
                end else begin
                    lcp_we = 1'b1; lcp_wa = r_r; lcp_wd = r_h[AW-1:0];
                end
            end
            salcp_pkg::OP_LNX: begin
                if (end_n) begin
                    n_i = '0; n_ready = 1'b1;
                end else begin
                    n_i = r_i + LW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (txt_we) m_txt[txt_wa] <= txt_wd;
        if (txt_re) r_txt_q <= m_txt[txt_ra];
    end
    always_ff @(posedge i_clk) begin
        if (sa_we) m_sa[sa_wa] <= sa_wd;
        if (sa_re) r_sa_q <= m_sa[sa_ra];
    end
    always_ff @(posedge i_clk) begin
        if (tmp_we) m_tmp[tmp_wa] <= tmp_wd;
        if (tmp_re) r_tmp_q <= m_tmp[tmp_ra];
    end
    always_ff @(posedge i_clk) begin
        if (cls_we) m_cls[cls_wa] <= cls_wd;
        if (cls_re) r_cls_q <= m_cls[cls_ra];
    end
    always_ff @(posedge i_clk) begin
        if (ncls_we) m_ncls[ncls_wa] <= ncls_wd;
        if (ncls_re) r_ncls_q <= m_ncls[ncls_ra];
    end
    always_ff @(posedge i_clk) begin
        if (cnt_we) m_cnt[cnt_wa] <= cnt_wd;
        if (cnt_re) r_cnt_q <= m_cnt[cnt_ra];
    end
    always_ff @(posedge i_clk) begin
        if (rk_we) m_rk[rk_wa] <= rk_wd;
        if (rk_re) r_rk_q <= m_rk[rk_ra];
    end
    always_ff @(posedge i_clk) begin
        if (lcp_we) m_lcp[lcp_wa] <= lcp_wd;
        if (lcp_re) r_lcp_q <= m_lcp[lcp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_ready <= 1'b0;
            r_init  <= 1'b0;
            r_ct    <= LW'(1);
        end else begin
            r_len   <= n_len;
            r_ovf   <= n_ovf;
            r_ready <= n_ready;
            r_init  <= n_init;
            r_ct    <= n_ct;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_h <= n_h; r_step <= n_step; r_acc <= n_acc;
        r_qin <= n_qin; r_qnext <= n_qnext; r_a <= n_a; r_ca <= n_ca;
        r_pca <= n_pca; r_pcm <= n_pcm; r_r <= n_r; r_nx <= n_nx;
        r_psym <= n_psym; r_ta <= n_ta;
        r_o_start <= n_o_start; r_o_cp <= n_o_cp; r_o_hn <= n_o_hn;
        r_o_ir <= n_o_ir; r_o_ov <= n_o_ov;
    end

endmodule

/* rtl/salcp_ctrl.sv */
// ----------------------------------------------------------------------------
// salcp_ctrl
// sequencer: input handshake, result valid and the sort / lcp pass order
// ----------------------------------------------------------------------------
module salcp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_func,
    input  logic              i_last,
    input  logic              i_out_taken,
    input  salcp_pkg::t_stat  i_stat,
    output salcp_pkg::t_op    o_op,
    output logic              o_ready,
    output logic              o_out_valid
);
    typedef enum logic [39:0] {
        S_IDLE = 40'd1 << 0,  S_QOUT = 40'd1 << 1,  S_CLR  = 40'd1 << 2,
        S_IC1  = 40'd1 << 3,  S_IC2  = 40'd1 << 4,  S_IC3  = 40'd1 << 5,
        S_DC1  = 40'd1 << 6,  S_DC2  = 40'd1 << 7,  S_DC3  = 40'd1 << 8,
        S_DC4  = 40'd1 << 9,  S_PR1  = 40'd1 << 10, S_PR2  = 40'd1 << 11,
        S_IP1  = 40'd1 << 12, S_IP2  = 40'd1 << 13, S_IP3  = 40'd1 << 14,
        S_IK1  = 40'd1 << 15, S_IK2  = 40'd1 << 16, S_IK3  = 40'd1 << 17,
        S_SH1  = 40'd1 << 18, S_SH2  = 40'd1 << 19, S_DP1  = 40'd1 << 20,
        S_DP2  = 40'd1 << 21, S_DP3  = 40'd1 << 22, S_DP4  = 40'd1 << 23,
        S_DK1  = 40'd1 << 24, S_DK2  = 40'd1 << 25, S_DK3  = 40'd1 << 26,
        S_DK4  = 40'd1 << 27, S_CP1  = 40'd1 << 28, S_CP2  = 40'd1 << 29,
        S_STEP = 40'd1 << 30, S_RK1  = 40'd1 << 31, S_RK2  = 40'd1 << 32,
        S_LC1  = 40'd1 << 33, S_LC2  = 40'd1 << 34, S_LC3  = 40'd1 << 35,
        S_LC4  = 40'd1 << 36, S_LC5  = 40'd1 << 37, S_LC6  = 40'd1 << 38,
        S_LNX  = 40'd1 << 39
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    assign o_ready     = (r_state == S_IDLE) && !r_ovalid;
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !i_out_taken;
        o_op     = salcp_pkg::OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    if (i_func) begin
                        o_op = salcp_pkg::OP_QUERY; n_state = S_QOUT;
                    end else begin
                        o_op = salcp_pkg::OP_LOAD;
                        if (i_last) n_state = S_CLR;
                    end
                end
            end
            S_QOUT: begin
                o_op = salcp_pkg::OP_OUT; n_ovalid = 1'b1; n_state = S_IDLE;
            end
            S_CLR: begin
                o_op = salcp_pkg::OP_CLR;
                if (i_stat.end_bk) n_state = i_stat.init ? S_IC1 : S_DC1;
            end
            S_IC1: begin o_op = salcp_pkg::OP_IC1; n_state = S_IC2; end
            S_IC2: begin o_op = salcp_pkg::OP_IC2; n_state = S_IC3; end
            S_IC3: begin
                o_op = salcp_pkg::OP_IC3; n_state = i_stat.end_n ? S_PR1 : S_IC1;
            end
            S_DC1: begin o_op = salcp_pkg::OP_DC1; n_state = S_DC2; end
            S_DC2: begin o_op = salcp_pkg::OP_DC2; n_state = S_DC3; end
            S_DC3: begin o_op = salcp_pkg::OP_DC3; n_state = S_DC4; end
            S_DC4: begin
                o_op = salcp_pkg::OP_DC4; n_state = i_stat.end_n ? S_PR1 : S_DC1;
            end
            S_PR1: begin o_op = salcp_pkg::OP_PR1; n_state = S_PR2; end
            S_PR2: begin
                o_op = salcp_pkg::OP_PR2;
                if (i_stat.end_lim) n_state = i_stat.init ? S_IP1 : S_DP1;
                else n_state = S_PR1;
            end
            S_IP1: begin o_op = salcp_pkg::OP_IP1; n_state = S_IP2; end
            S_IP2: begin o_op = salcp_pkg::OP_IP2; n_state = S_IP3; end
            S_IP3: begin
                o_op = salcp_pkg::OP_IP3; n_state = i_stat.end_n ? S_IK1 : S_IP1;
            end
            S_IK1: begin o_op = salcp_pkg::OP_IK1; n_state = S_IK2; end
            S_IK2: begin o_op = salcp_pkg::OP_IK2; n_state = S_IK3; end
            S_IK3: begin
                o_op = salcp_pkg::OP_IK3;
                if (i_stat.end_n) n_state = i_stat.step_go ? S_SH1 : S_RK1;
                else n_state = S_IK1;
            end
            S_SH1: begin o_op = salcp_pkg::OP_SH1; n_state = S_SH2; end
            S_SH2: begin
                o_op = salcp_pkg::OP_SH2; n_state = i_stat.end_n ? S_CLR : S_SH1;
            end
            S_DP1: begin o_op = salcp_pkg::OP_DP1; n_state = S_DP2; end
            S_DP2: begin o_op = salcp_pkg::OP_DP2; n_state = S_DP3; end
            S_DP3: begin o_op = salcp_pkg::OP_DP3; n_state = S_DP4; end
            S_DP4: begin
                o_op = salcp_pkg::OP_DP4; n_state = i_stat.i_zero ? S_DK1 : S_DP1;
            end
            S_DK1: begin o_op = salcp_pkg::OP_DK1; n_state = S_DK2; end
            S_DK2: begin o_op = salcp_pkg::OP_DK2; n_state = S_DK3; end
            S_DK3: begin o_op = salcp_pkg::OP_DK3; n_state = S_DK4; end
            S_DK4: begin
                o_op = salcp_pkg::OP_DK4; n_state = i_stat.end_n ? S_CP1 : S_DK1;
            end
            S_CP1: begin o_op = salcp_pkg::OP_CP1; n_state = S_CP2; end
            S_CP2: begin
                o_op = salcp_pkg::OP_CP2; n_state = i_stat.end_n ? S_STEP : S_CP1;
            end
            S_STEP: begin
                o_op = salcp_pkg::OP_STEP; n_state = i_stat.step_go ? S_SH1 : S_RK1;
            end
            S_RK1: begin o_op = salcp_pkg::OP_RK1; n_state = S_RK2; end
            S_RK2: begin
                o_op = salcp_pkg::OP_RK2; n_state = i_stat.end_n ? S_LC1 : S_RK1;
            end
            S_LC1: begin o_op = salcp_pkg::OP_LC1; n_state = S_LC2; end
            S_LC2: begin
                o_op = salcp_pkg::OP_LC2; n_state = i_stat.r_last ? S_LNX : S_LC3;
            end
            S_LC3: begin o_op = salcp_pkg::OP_LC3; n_state = S_LC4; end
            S_LC4: begin
                o_op = salcp_pkg::OP_LC4; n_state = i_stat.scan_ok ? S_LC5 : S_LNX;
            end
            S_LC5: begin o_op = salcp_pkg::OP_LC5; n_state = S_LC6; end
            S_LC6: begin
                o_op = salcp_pkg::OP_LC6; n_state = i_stat.sym_eq ? S_LC4 : S_LNX;
            end
            S_LNX: begin
                o_op = salcp_pkg::OP_LNX; n_state = i_stat.end_n ? S_IDLE : S_LC1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule
